// ----- rtl/nict_pkg.sv -----
// Shared types and constants for the non-INVITE client transaction unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package nict_pkg;

   // Item action codes
   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_RESP = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // Transaction phase as reported on txn_state
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_TRYING     = 3'd1,
      PH_PROCEEDING = 3'd2,
      PH_COMPLETED  = 3'd3,
      PH_TERMINATED = 3'd4
   } phase_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_T1        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_T2        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_E_DEFAULT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_K_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIFETIME  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELIABLE  = 3'd5;

   // Field widths
   localparam int unsigned TIMER_W    = 16;
   localparam int unsigned TIMEOUT_W  = 22;
   localparam int unsigned LIFETIME_W = 24;
   // Timer F is timer E scaled by 64, so the override is divided by 64
   localparam int unsigned F_SHIFT    = 6;

   // Reset values of the configuration registers
   localparam logic [TIMER_W-1:0]    T2_RESET        = 16'd4000;
   localparam logic [TIMER_W-1:0]    E_DEFAULT_RESET = 16'd500;
   localparam logic [TIMER_W-1:0]    K_TICKS_RESET   = 16'd5000;
   localparam logic [LIFETIME_W-1:0] LIFETIME_RESET  = 24'd300000;

   typedef struct packed {
      logic [TIMER_W-1:0]    timer_t2;
      logic [TIMER_W-1:0]    timer_e_default;
      logic [TIMER_W-1:0]    timer_k_ticks;
      logic [LIFETIME_W-1:0] max_lifetime;
      logic                  reliable;
   } cfg_type;

   typedef struct packed {
      action_type           action;
      logic                 response_is_final;
      logic [TIMEOUT_W-1:0] timeout_override;
   } item_type;

   typedef struct packed {
      logic      accepted;
      logic      send_request;
      logic      inform_user;
      logic      timed_out;
      logic      terminated;
      phase_type txn_state;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/nict_csr.sv -----
// Configuration register bank of the non-INVITE client transaction unit.
// Depends on nict_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module nict_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [nict_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [nict_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output nict_pkg::cfg_type                        cfg
);

   nict_pkg::cfg_type cfg_ff;
   nict_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; timer T1 is accepted but holds nothing the logic uses
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nict_pkg::CSR_T2:        cfg_in.timer_t2 = csr_wdata[nict_pkg::TIMER_W-1:0];
            nict_pkg::CSR_E_DEFAULT: cfg_in.timer_e_default =
                                        csr_wdata[nict_pkg::TIMER_W-1:0];
            nict_pkg::CSR_K_TICKS:   cfg_in.timer_k_ticks = csr_wdata[nict_pkg::TIMER_W-1:0];
            nict_pkg::CSR_LIFETIME:  cfg_in.max_lifetime =
                                        csr_wdata[nict_pkg::LIFETIME_W-1:0];
            nict_pkg::CSR_RELIABLE:  cfg_in.reliable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_t2        <= nict_pkg::T2_RESET;
         cfg_ff.timer_e_default <= nict_pkg::E_DEFAULT_RESET;
         cfg_ff.timer_k_ticks   <= nict_pkg::K_TICKS_RESET;
         cfg_ff.max_lifetime    <= nict_pkg::LIFETIME_RESET;
         cfg_ff.reliable        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/nict_ctl.sv -----
// Transaction state machine and timers E, F, K and lifetime.
// Depends on nict_pkg; updates state once per item on the fire strobe.
`default_nettype none

module nict_ctl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire nict_pkg::item_type  item,
   input  wire nict_pkg::cfg_type   cfg,
   output nict_pkg::result_type     result
);

   nict_pkg::phase_type               phase_ff, phase_in;
   logic [nict_pkg::TIMER_W-1:0]      retx_ivl_ff, retx_ivl_in;
   logic [nict_pkg::TIMER_W-1:0]      retx_cnt_ff, retx_cnt_in;
   logic                              retx_run_ff, retx_run_in;
   logic [nict_pkg::TIMEOUT_W-1:0]    to_cnt_ff, to_cnt_in;
   logic                              to_run_ff, to_run_in;
   logic [nict_pkg::TIMER_W-1:0]      lin_cnt_ff, lin_cnt_in;
   logic                              lin_run_ff, lin_run_in;
   logic [nict_pkg::LIFETIME_W-1:0]   life_cnt_ff, life_cnt_in;
   logic                              life_run_ff, life_run_in;

   logic [nict_pkg::TIMER_W-1:0]      init_e;
   logic [nict_pkg::TIMER_W:0]        doubled;
   logic                              active;
   logic                              f_exp, l_exp, k_exp, e_exp;

   // Expiry: a running timer at 0 or 1 expires on this tick
   assign f_exp  = to_run_ff   && (to_cnt_ff   <= nict_pkg::TIMEOUT_W'(1));
   assign l_exp  = life_run_ff && (life_cnt_ff <= nict_pkg::LIFETIME_W'(1));
   assign k_exp  = lin_run_ff  && (lin_cnt_ff  <= nict_pkg::TIMER_W'(1));
   assign e_exp  = retx_run_ff && (retx_cnt_ff <= nict_pkg::TIMER_W'(1));
   assign active = (phase_ff == nict_pkg::PH_TRYING) ||
                   (phase_ff == nict_pkg::PH_PROCEEDING);

   // Initial timer E: override divided by 64, else the default
   assign init_e  = (item.timeout_override != '0) ?
                    item.timeout_override[nict_pkg::TIMEOUT_W-1:nict_pkg::F_SHIFT] :
                    cfg.timer_e_default;
   assign doubled = {retx_ivl_ff, 1'b0};

   // Next state and result for the item in the input register
   always_comb begin
      phase_in    = phase_ff;
      retx_ivl_in = retx_ivl_ff;
      retx_cnt_in = retx_cnt_ff;
      retx_run_in = retx_run_ff;
      to_cnt_in   = to_cnt_ff;
      to_run_in   = to_run_ff;
      lin_cnt_in  = lin_cnt_ff;
      lin_run_in  = lin_run_ff;
      life_cnt_in = life_cnt_ff;
      life_run_in = life_run_ff;
      result      = '0;

      unique case (item.action)
         nict_pkg::ACT_SEND: begin
            if (phase_ff == nict_pkg::PH_IDLE) begin
               result.accepted     = 1'b1;
               result.send_request = 1'b1;
               phase_in    = nict_pkg::PH_TRYING;
               retx_ivl_in = init_e;
               retx_cnt_in = init_e;
               retx_run_in = !cfg.reliable;
               to_cnt_in   = {init_e, {nict_pkg::F_SHIFT{1'b0}}};
               to_run_in   = 1'b1;
               life_cnt_in = cfg.max_lifetime;
               life_run_in = 1'b1;
               lin_run_in  = 1'b0;
            end
         end
         nict_pkg::ACT_RESP: begin
            if (active) begin
               result.inform_user = 1'b1;
               if (!item.response_is_final) begin
                  phase_in = nict_pkg::PH_PROCEEDING;
               end else if (!cfg.reliable) begin
                  // Final on unreliable transport: linger in completed
                  phase_in    = nict_pkg::PH_COMPLETED;
                  retx_run_in = 1'b0;
                  to_run_in   = 1'b0;
                  lin_cnt_in  = cfg.timer_k_ticks;
                  lin_run_in  = 1'b1;
               end else begin
                  phase_in          = nict_pkg::PH_TERMINATED;
                  result.terminated = 1'b1;
                  retx_run_in = 1'b0;
                  to_run_in   = 1'b0;
                  lin_run_in  = 1'b0;
                  life_run_in = 1'b0;
               end
            end
         end
         nict_pkg::ACT_TICK: begin
            if (phase_ff != nict_pkg::PH_IDLE && phase_ff != nict_pkg::PH_TERMINATED) begin
               // Count down every running timer
               if (to_run_ff) begin
                  to_cnt_in = f_exp ? '0 : to_cnt_ff - nict_pkg::TIMEOUT_W'(1);
                  to_run_in = !f_exp;
               end
               if (life_run_ff) begin
                  life_cnt_in = l_exp ? '0 : life_cnt_ff - nict_pkg::LIFETIME_W'(1);
                  life_run_in = !l_exp;
               end
               if (lin_run_ff) begin
                  lin_cnt_in = k_exp ? '0 : lin_cnt_ff - nict_pkg::TIMER_W'(1);
                  lin_run_in = !k_exp;
               end
               if (retx_run_ff) begin
                  retx_cnt_in = e_exp ? '0 : retx_cnt_ff - nict_pkg::TIMER_W'(1);
                  retx_run_in = !e_exp;
               end

               // Timer F wins over lifetime and timer K
               if (f_exp && active) begin
                  result.timed_out  = 1'b1;
                  result.terminated = 1'b1;
               end else if (l_exp || k_exp) begin
                  result.terminated = 1'b1;
               end

               if (result.terminated) begin
                  phase_in    = nict_pkg::PH_TERMINATED;
                  retx_run_in = 1'b0;
                  to_run_in   = 1'b0;
                  lin_run_in  = 1'b0;
                  life_run_in = 1'b0;
               end else if (e_exp && active) begin
                  // Retransmit; back off up to T2 while trying, hold T2 while proceeding
                  result.send_request = 1'b1;
                  if (phase_ff == nict_pkg::PH_TRYING &&
                      doubled <= {1'b0, cfg.timer_t2}) begin
                     retx_ivl_in = doubled[nict_pkg::TIMER_W-1:0];
                     retx_cnt_in = doubled[nict_pkg::TIMER_W-1:0];
                  end else begin
                     retx_ivl_in = cfg.timer_t2;
                     retx_cnt_in = cfg.timer_t2;
                  end
                  retx_run_in = 1'b1;
               end
            end
         end
         default: ;
      endcase

      result.txn_state = phase_in;
   end

   // Commit state when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= nict_pkg::PH_IDLE;
         retx_ivl_ff <= '0;
         retx_cnt_ff <= '0;
         retx_run_ff <= 1'b0;
         to_cnt_ff   <= '0;
         to_run_ff   <= 1'b0;
         lin_cnt_ff  <= '0;
         lin_run_ff  <= 1'b0;
         life_cnt_ff <= '0;
         life_run_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         retx_ivl_ff <= retx_ivl_in;
         retx_cnt_ff <= retx_cnt_in;
         retx_run_ff <= retx_run_in;
         to_cnt_ff   <= to_cnt_in;
         to_run_ff   <= to_run_in;
         lin_cnt_ff  <= lin_cnt_in;
         lin_run_ff  <= lin_run_in;
         life_cnt_ff <= life_cnt_in;
         life_run_ff <= life_run_in;
      end
   end

   // Timers E and F only run while the request is outstanding
   assert property (@(posedge clock) disable iff (reset)
      (retx_run_ff || to_run_ff) |->
         (phase_ff == nict_pkg::PH_TRYING || phase_ff == nict_pkg::PH_PROCEEDING))
      else $error("timer E or F running outside trying/proceeding");

   // Timer K only runs in completed
   assert property (@(posedge clock) disable iff (reset)
      lin_run_ff |-> (phase_ff == nict_pkg::PH_COMPLETED))
      else $error("timer K running outside completed");

   // A terminated transaction stays terminated
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == nict_pkg::PH_TERMINATED) |=> (phase_ff == nict_pkg::PH_TERMINATED))
      else $error("transaction left terminated");

   // An accepted send leaves the transaction in trying with timer F loaded
   assert property (@(posedge clock) disable iff (reset)
      (fire && result.accepted) |=> (phase_ff == nict_pkg::PH_TRYING && to_run_ff))
      else $error("accepted send did not start the transaction");

   // Nothing runs once terminated or idle
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == nict_pkg::PH_IDLE || phase_ff == nict_pkg::PH_TERMINATED) |->
         !(retx_run_ff || to_run_ff || lin_run_ff || life_run_ff))
      else $error("timer running while idle or terminated");

endmodule

`default_nettype wire

// ----- rtl/sip_non_invite_client_transaction_unit.sv -----
// Top level of the non-INVITE client transaction unit: input register, result register.
// Depends on nict_pkg, nict_csr and nict_ctl.
//
// Takes one transaction per clock cycle: a send, a response or a timer tick. Each
// transaction is captured in an input register, passes once through the state
// update logic, and its result lands in a result register; the throughput is one
// transaction per cycle while the result side takes them, and the state update between
// the two registers sets that figure. The input side keeps accepting while a result
// waits, up to one held transaction. Configuration writes are taken every cycle and
// apply at the next timer load; write them only while no transaction is in flight.
// Timer T1 can be written but does not affect behavior.
`default_nettype none

module sip_non_invite_client_transaction_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_action,
   input  wire logic                              req_response_is_final,
   input  wire logic [nict_pkg::TIMEOUT_W-1:0]    req_timeout_override,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_accepted,
   output logic                                   rsp_send_request,
   output logic                                   rsp_inform_user,
   output logic                                   rsp_timed_out,
   output logic                                   rsp_terminated,
   output logic [2:0]                             rsp_txn_state,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [nict_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [nict_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   nict_pkg::cfg_type    cfg;
   nict_pkg::item_type   item_ff;
   logic                 in_valid_ff, in_valid_in;
   nict_pkg::result_type result;
   nict_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 fire;
   logic                 req_take;

   nict_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nict_ctl u_ctl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance when the result register is free or being emptied
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   // Input register valid
   always_comb begin
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Result register valid
   always_comb begin
      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the transaction and its result
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action            <= nict_pkg::action_type'(req_action);
         item_ff.response_is_final <= req_response_is_final;
         item_ff.timeout_override  <= req_timeout_override;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_send_request = rsp_ff.send_request;
   assign rsp_inform_user  = rsp_ff.inform_user;
   assign rsp_timed_out    = rsp_ff.timed_out;
   assign rsp_terminated   = rsp_ff.terminated;
   assign rsp_txn_state    = 3'(rsp_ff.txn_state);

endmodule

`default_nettype wire
